// ===== hw/rtl/tccw_pkg.sv =====
// Shared constants, codes and control structures of the text console cursor writer.
`timescale 1ns / 1ps

package tccw_pkg;

	// Operation codes carried by the request beat.
	localparam logic [1:0] OP_PRINT = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;
	localparam logic [7:0] CH_TAB     = 8'd9;

	localparam logic [7:0] DEFAULT_ATTR = 8'h07;
	localparam int         TAB_STOP     = 4;

	// Register index, taken from bit 2 of the byte address.
	localparam logic REG_TEXT_ATTR = 1'b0;

	// Source of the data written into the screen store.
	localparam logic [1:0] WSRC_FILL   = 2'd0;
	localparam logic [1:0] WSRC_SCROLL = 2'd1;
	localparam logic [1:0] WSRC_PUT    = 2'd2;

	typedef struct packed {
		logic       take_req;
		logic       mem_we;
		logic [1:0] wsel;
		logic       fill_dflt;
		logic       rd_read;
		logic       rd_scroll;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       home;
		logic       row_inc;
		logic       col_zero;
		logic       col_inc;
		logic       out_load;
	} tccw_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       is_nl;
		logic       is_cr;
		logic       is_tab;
		logic       col_full;
		logic       row_last;
		logic       fill_last;
		logic       scroll_last;
		logic       tab_stop;
		logic       out_free;
	} tccw_sts_t;

endpackage

// ===== hw/rtl/tccw_if.sv =====
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface tccw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  character;
	logic [10:0] cell_address;

	modport source (output valid, output operation, output character, output cell_address,
		input ready);
	modport sink (input valid, input operation, input character, input cell_address,
		output ready);
endinterface

interface tccw_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_value;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_column;

	modport source (output valid, output cell_value, output cursor_row, output cursor_column,
		input ready);
	modport sink (input valid, input cell_value, input cursor_row, input cursor_column,
		output ready);
endinterface

// ===== hw/rtl/text_console_cursor_writer.sv =====
// Top level of the text console cursor writer: channels, register port and assertions.
//
//  channel | role    | beat carries
//  --------+---------+-------------------------------------------------
//  req     | sink    | operation, character, cell_address
//  rsp     | source  | cell_value, cursor_row, cursor_column
//  apb     | slave   | text_attribute at byte address 0
//
// One request is worked at a time. A tab makes one store write per padding cell.
// Clear and reset sweep the store one cell a cycle, and a scroll reads and then writes
// each moved cell in turn. After reset a clearing pass over every cell runs before
// req.ready rises. A held response stalls only the final state of the next request.
`timescale 1ns / 1ps

module text_console_cursor_writer #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	tccw_req_if.sink          req,
	tccw_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [7:0]          text_attribute_q;
	tccw_pkg::tccw_cmd_t cmd;
	tccw_pkg::tccw_sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= tccw_pkg::DEFAULT_ATTR;
		end else if (psel && penable && pwrite && paddr[2] == tccw_pkg::REG_TEXT_ATTR) begin
			text_attribute_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == tccw_pkg::REG_TEXT_ATTR) ? {24'h000000, text_attribute_q}
		: 32'h00000000;

	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tccw_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.text_attribute (text_attribute_q),
		.operation      (req.operation),
		.character      (req.character),
		.cell_address   (req.cell_address),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.cell_value     (rsp.cell_value),
		.cursor_row     (rsp.cursor_row),
		.cursor_column  (rsp.cursor_column)
	);

`ifndef SYNTHESIS
	// Only one request is in work, so ready must drop straight after an accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is still in work");

	// The screen store is never written while the block is waiting for a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> !req.ready)
		else $error("screen store written while idle");

	// Scrolling is only ever started from the bottom row.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_scroll |-> sts.row_last)
		else $error("scroll read issued away from the last row");

	// A response beat is loaded only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("response register overwritten before it was taken");
`endif

endmodule

// ===== hw/rtl/tccw_ctrl.sv =====
// Controller state machine sequencing each operation over the datapath.
`timescale 1ns / 1ps

module tccw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  tccw_pkg::tccw_sts_t sts,
	output tccw_pkg::tccw_cmd_t cmd
);

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DISP = 4'd2;
	localparam logic [3:0] ST_FILL = 4'd3;
	localparam logic [3:0] ST_SCRD = 4'd4;
	localparam logic [3:0] ST_SCWR = 4'd5;
	localparam logic [3:0] ST_PUT  = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;

	logic [3:0] state_q, state_d;
	logic       pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pend_d    = pend_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				// Power-up pass: every cell gets a space in the default colour.
				cmd.mem_we    = 1'b1;
				cmd.wsel      = tccw_pkg::WSRC_FILL;
				cmd.fill_dflt = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take_req = 1'b1;
					state_d      = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.op)
					tccw_pkg::OP_PRINT: begin
						if (sts.is_nl) begin
							cmd.col_zero = 1'b1;
							if (sts.row_last) begin
								cmd.cnt_clr = 1'b1;
								pend_d      = 1'b0;
								state_d     = ST_SCRD;
							end else begin
								cmd.row_inc = 1'b1;
								state_d     = ST_EMIT;
							end
						end else if (sts.is_cr) begin
							cmd.col_zero = 1'b1;
							state_d      = ST_EMIT;
						end else if (sts.col_full) begin
							// A full line wraps before anything is written.
							cmd.col_zero = 1'b1;
							if (sts.row_last) begin
								cmd.cnt_clr = 1'b1;
								pend_d      = 1'b1;
								state_d     = ST_SCRD;
							end else begin
								cmd.row_inc = 1'b1;
								state_d     = ST_PUT;
							end
						end else begin
							state_d = ST_PUT;
						end
					end
					tccw_pkg::OP_CLEAR, tccw_pkg::OP_RESET: begin
						cmd.home    = 1'b1;
						cmd.cnt_clr = 1'b1;
						state_d     = ST_FILL;
					end
					default: begin
						cmd.rd_read = 1'b1;
						state_d     = ST_EMIT;
					end
				endcase
			end
			ST_FILL: begin
				cmd.mem_we    = 1'b1;
				cmd.wsel      = tccw_pkg::WSRC_FILL;
				cmd.fill_dflt = (sts.op == tccw_pkg::OP_RESET);
				cmd.cnt_inc   = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_SCRD: begin
				cmd.rd_scroll = 1'b1;
				state_d       = ST_SCWR;
			end
			ST_SCWR: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = tccw_pkg::WSRC_SCROLL;
				cmd.cnt_inc = 1'b1;
				if (sts.scroll_last) begin
					state_d = pend_q ? ST_PUT : ST_EMIT;
				end else begin
					state_d = ST_SCRD;
				end
			end
			ST_PUT: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = tccw_pkg::WSRC_PUT;
				cmd.col_inc = 1'b1;
				if (!sts.is_tab || sts.tab_stop) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/tccw_dp.sv =====
// Datapath: request latch, cursor, screen store, sweep counter and response register.
`timescale 1ns / 1ps

module tccw_dp #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tccw_pkg::tccw_cmd_t cmd,
	output tccw_pkg::tccw_sts_t sts,
	input  logic [7:0]          text_attribute,
	input  logic [1:0]          operation,
	input  logic [7:0]          character,
	input  logic [10:0]         cell_address,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic [15:0]         cell_value,
	output logic [4:0]          cursor_row,
	output logic [6:0]          cursor_column
);

	localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW     = $clog2(CELLS);
	localparam int RW     = $clog2(SCREEN_HEIGHT);
	localparam int CW     = $clog2(SCREEN_WIDTH + 1);
	localparam int IW     = (AW > 11) ? AW : 11;
	localparam int ROW_OW = (RW > 5) ? RW : 5;
	localparam int COL_OW = (CW > 7) ? CW : 7;

	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_SCROLL = AW'(SCREEN_WIDTH * (SCREEN_HEIGHT - 1) - 1);
	localparam logic [AW-1:0] ROW_STRIDE  = AW'(SCREEN_WIDTH);
	localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_HEIGHT - 1);
	localparam logic [CW-1:0] FULL_COL    = CW'(SCREEN_WIDTH);
	localparam logic [CW-1:0] TAB_MASK    = CW'(tccw_pkg::TAB_STOP - 1);

	logic [1:0]    op_q;
	logic [7:0]    char_q;
	logic [10:0]   addr_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] cnt_q;
	logic [15:0]   rd_q;
	logic          out_valid_q;
	logic [15:0]   value_q;
	logic [4:0]    row_out_q;
	logic [6:0]    col_out_q;

	logic [15:0]     mem [CELLS];
	logic [IW-1:0]   addr_ext;
	logic            in_range;
	logic [AW-1:0]   put_addr;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [15:0]     wdata;
	logic [7:0]      fill_attr;
	logic [CW-1:0]   next_col;
	logic [ROW_OW-1:0] row_wide;
	logic [COL_OW-1:0] col_wide;

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			op_q   <= operation;
			char_q <= character;
			addr_q <= cell_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.home) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + 1'b1;
			end
			if (cmd.home || cmd.col_zero) begin
				col_q <= '0;
			end else if (cmd.col_inc) begin
				col_q <= next_col;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign addr_ext  = IW'(addr_q);
	assign in_range  = addr_ext < IW'(CELLS);
	assign put_addr  = AW'(row_q) * ROW_STRIDE + AW'(col_q);
	assign next_col  = col_q + 1'b1;
	assign fill_attr = cmd.fill_dflt ? tccw_pkg::DEFAULT_ATTR : text_attribute;
	assign waddr     = (cmd.wsel == tccw_pkg::WSRC_PUT) ? put_addr : cnt_q;
	// Scroll reads one row below the cell being written.
	assign raddr     = cmd.rd_read ? addr_ext[AW-1:0] : cnt_q + ROW_STRIDE;

	always_comb begin
		case (cmd.wsel)
			tccw_pkg::WSRC_FILL:   wdata = {fill_attr, tccw_pkg::CH_SPACE};
			tccw_pkg::WSRC_SCROLL: wdata = rd_q;
			default: begin
				wdata = {text_attribute, (char_q == tccw_pkg::CH_TAB) ? tccw_pkg::CH_SPACE : char_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_read || cmd.rd_scroll) begin
			rd_q <= mem[raddr];
		end
	end

	assign row_wide = ROW_OW'(row_q);
	assign col_wide = COL_OW'(col_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q   <= (op_q == tccw_pkg::OP_READ && in_range) ? rd_q : 16'h0000;
			row_out_q <= row_wide[4:0];
			col_out_q <= col_wide[6:0];
		end
	end

	assign sts.op          = op_q;
	assign sts.is_nl       = (char_q == tccw_pkg::CH_NEWLINE);
	assign sts.is_cr       = (char_q == tccw_pkg::CH_RETURN);
	assign sts.is_tab      = (char_q == tccw_pkg::CH_TAB);
	assign sts.col_full    = (col_q >= FULL_COL);
	assign sts.row_last    = (row_q == LAST_ROW);
	assign sts.fill_last   = (cnt_q == LAST_CELL);
	assign sts.scroll_last = (cnt_q == LAST_SCROLL);
	assign sts.tab_stop    = ((next_col & TAB_MASK) == '0) || (next_col >= FULL_COL);
	assign sts.out_free    = !out_valid_q || rsp_ready;

	assign rsp_valid     = out_valid_q;
	assign cell_value    = value_q;
	assign cursor_row    = row_out_q;
	assign cursor_column = col_out_q;

endmodule
